// ===== design/descending_bubble_sort_with_tag_unit_defines.svh =====
// ----------------------------------------------------------------------------
// descending bubble sort unit assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef DESCENDING_BUBBLE_SORT_WITH_TAG_UNIT_DEFINES_SVH
`define DESCENDING_BUBBLE_SORT_WITH_TAG_UNIT_DEFINES_SVH

// property must hold at every rising clock edge out of reset
`define DBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define DBS_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== design/dbs_pkg.sv =====
// ----------------------------------------------------------------------------
// dbs_pkg
// types and constants of the descending bubble sort unit
// ----------------------------------------------------------------------------
package dbs_pkg;

  localparam int unsigned PRICE_W = 31;
  localparam int unsigned TAG_W   = 8;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [TAG_W-1:0]   tag;
  } record_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FIRST,
    ST_STEP,
    ST_END,
    ST_OUT_FETCH,
    ST_OUT_LOAD,
    ST_OUT_SEND
  } state_e;

endpackage

// ===== design/descending_bubble_sort_with_tag_unit.sv =====
// ----------------------------------------------------------------------------
// descending_bubble_sort_with_tag_unit
// collects tagged price records, sorts them largest price first and streams
// them out with a last flag and an overflow flag
// ----------------------------------------------------------------------------
// Records are taken one per cycle while loading. The transaction flagged
// last ends the set: the n stored records (n at most CAPACITY, extra ones
// are dropped and raise overflow on every result) are bubble-sorted in a
// single-port-read record memory with a registered read, holding the
// bubbling record in a carry register. Pass k covers the first n-k+1
// entries; equal prices keep their load order. Output then fetches the
// first result, and each result passes a load state and a send state;
// the next one is read only once the previous result has been accepted.
// No input is taken from the last of a set until its final result has
// been accepted.
// ----------------------------------------------------------------------------
`include "descending_bubble_sort_with_tag_unit_defines.svh"

module descending_bubble_sort_with_tag_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dbs_pkg::PRICE_W-1:0] price_i,
  input  logic [dbs_pkg::TAG_W-1:0]   tag_i,
  input  logic                        last_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dbs_pkg::PRICE_W-1:0] sorted_price_o,
  output logic [dbs_pkg::TAG_W-1:0]   sorted_tag_o,
  output logic                        last_out_o,
  output logic                        overflow_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  dbs_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             drop_q, drop_d;
  logic [AW-1:0]    lim_q, lim_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [AW-1:0]    out_idx_q, out_idx_d;
  dbs_pkg::record_t carry_q, carry_d;
  logic             out_valid_q, out_valid_d;
  dbs_pkg::record_t out_rec_q, out_rec_d;
  logic             last_out_q, last_out_d;
  logic             ovf_q, ovf_d;

  dbs_pkg::record_t mem_q [CAPACITY];
  dbs_pkg::record_t rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  dbs_pkg::record_t mem_wd;

  logic             in_fire, out_fire, has_room, swap;
  logic [CW-1:0]    n_next, n_next_m1, fill_m1;
  logic [AW-1:0]    last_idx;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_q && out_ready_i;
  assign has_room  = fill_q < CW'(CAPACITY);
  assign n_next    = has_room ? fill_q + CW'(1) : fill_q;
  assign n_next_m1 = n_next - CW'(1);
  assign fill_m1   = fill_q - CW'(1);
  assign last_idx  = fill_m1[AW-1:0];
  assign swap      = carry_q.price < rdata_q.price;

  // record memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dbs_pkg::ST_LOAD: begin
        if (in_fire && last_in_i) begin
          state_d = (n_next == CW'(1)) ? dbs_pkg::ST_OUT_FETCH : dbs_pkg::ST_FIRST;
        end
      end
      dbs_pkg::ST_FIRST: state_d = dbs_pkg::ST_STEP;
      dbs_pkg::ST_STEP: begin
        if (addr_q == lim_q) begin
          state_d = dbs_pkg::ST_END;
        end
      end
      dbs_pkg::ST_END: begin
        state_d = (lim_q == AW'(1)) ? dbs_pkg::ST_OUT_FETCH : dbs_pkg::ST_FIRST;
      end
      dbs_pkg::ST_OUT_FETCH: state_d = dbs_pkg::ST_OUT_LOAD;
      dbs_pkg::ST_OUT_LOAD:  state_d = dbs_pkg::ST_OUT_SEND;
      dbs_pkg::ST_OUT_SEND: begin
        if (out_fire) begin
          state_d = last_out_q ? dbs_pkg::ST_LOAD : dbs_pkg::ST_OUT_LOAD;
        end
      end
      default: state_d = dbs_pkg::ST_LOAD;
    endcase
  end

  // outputs and datapath
  always_comb begin
    fill_d      = fill_q;
    drop_d      = drop_q;
    lim_d       = lim_q;
    addr_d      = addr_q;
    out_idx_d   = out_idx_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q;
    out_rec_d   = out_rec_q;
    last_out_d  = last_out_q;
    ovf_d       = ovf_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = carry_q;
    mem_re      = 1'b0;
    mem_ra      = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      dbs_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        out_idx_d  = '0;
        if (in_fire) begin
          fill_d = n_next;
          lim_d  = n_next_m1[AW-1:0];
          if (has_room) begin
            mem_we       = 1'b1;
            mem_wa       = fill_q[AW-1:0];
            mem_wd.price = price_i;
            mem_wd.tag   = tag_i;
          end else begin
            drop_d = 1'b1;
          end
          // first pass read of entry zero, never the entry written now
          if (last_in_i && n_next != CW'(1)) begin
            mem_re = 1'b1;
            mem_ra = '0;
          end
        end
      end
      dbs_pkg::ST_FIRST: begin
        carry_d = rdata_q;
        mem_re  = 1'b1;
        mem_ra  = AW'(1);
        addr_d  = AW'(1);
      end
      dbs_pkg::ST_STEP: begin
        mem_we  = 1'b1;
        mem_wa  = addr_q - AW'(1);
        mem_wd  = swap ? rdata_q : carry_q;
        carry_d = swap ? carry_q : rdata_q;
        if (addr_q != lim_q) begin
          mem_re = 1'b1;
          mem_ra = addr_q + AW'(1);
          addr_d = addr_q + AW'(1);
        end
      end
      dbs_pkg::ST_END: begin
        mem_we = 1'b1;
        mem_wa = lim_q;
        mem_wd = carry_q;
        if (lim_q != AW'(1)) begin
          lim_d  = lim_q - AW'(1);
          mem_re = 1'b1;
          mem_ra = '0;
        end
      end
      dbs_pkg::ST_OUT_FETCH: begin
        mem_re = 1'b1;
        mem_ra = out_idx_q;
      end
      dbs_pkg::ST_OUT_LOAD: begin
        out_valid_d = 1'b1;
        out_rec_d   = rdata_q;
        last_out_d  = out_idx_q == last_idx;
        ovf_d       = drop_q;
      end
      dbs_pkg::ST_OUT_SEND: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
          if (last_out_q) begin
            fill_d = '0;
            drop_d = 1'b0;
          end else begin
            mem_re    = 1'b1;
            mem_ra    = out_idx_q + AW'(1);
            out_idx_d = out_idx_q + AW'(1);
          end
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dbs_pkg::ST_LOAD;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      lim_q       <= '0;
      addr_q      <= '0;
      out_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      lim_q       <= lim_d;
      addr_q      <= addr_d;
      out_idx_q   <= out_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q    <= carry_d;
    out_rec_q  <= out_rec_d;
    last_out_q <= last_out_d;
    ovf_q      <= ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_price_o = out_rec_q.price;
  assign sorted_tag_o   = out_rec_q.tag;
  assign last_out_o     = last_out_q;
  assign overflow_o     = ovf_q;

  `DBS_ASSERT_NEVER(a_no_rw_collide, mem_we && mem_re && (mem_wa == mem_ra),
                    "read and write of the same entry in one cycle")
  `DBS_ASSERT(a_valid_in_send, out_valid_q |-> (state_q == dbs_pkg::ST_OUT_SEND),
              "result valid outside the send state")
  `DBS_ASSERT(a_step_bounds,
              (state_q == dbs_pkg::ST_STEP) |-> (addr_q != '0 && addr_q <= lim_q),
              "sort step address out of the pass range")
  `DBS_ASSERT(a_set_cleared, (out_fire && last_out_q) |=> (fill_q == '0 && !drop_q),
              "set state not cleared after the final transaction")

endmodule

// ===== tb/sv/tb_descending_bubble_sort_with_tag_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_descending_bubble_sort_with_tag_unit
// self-checking bench for the descending bubble sort unit: record sets are
// streamed in, a behavioral sorter predicts the sorted run with its last and
// overflow flags, and every result is compared against it in order, under
// random idling on both sides and one long output stall
// ----------------------------------------------------------------------------
module tb_descending_bubble_sort_with_tag_unit;

  localparam int unsigned PRICE_W = dbs_pkg::PRICE_W;
  localparam int unsigned TAG_W   = dbs_pkg::TAG_W;
  localparam int unsigned SORT_DEPTH = 16;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  typedef struct {
    logic [PRICE_W-1:0] price;
    logic [TAG_W-1:0]   tag;
    logic               last;
    logic               overflow;
  } sorted_result_t;

  typedef enum int {
    PRICE_ANY,
    PRICE_NARROW,
    PRICE_EXTREME
  } price_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [PRICE_W-1:0] price_i;
  logic [TAG_W-1:0]   tag_i;
  logic               last_in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [PRICE_W-1:0] sorted_price_o;
  logic [TAG_W-1:0]   sorted_tag_o;
  logic               last_out_o;
  logic               overflow_o;

  dbs_pkg::record_t held_records[$];
  logic             set_dropped;
  sorted_result_t   pending_results[$];

  bit tx_idle_en;
  bit rx_idle_en;
  int rx_hold_cycles;
  int error_count;
  int records_sent;
  int sets_sorted;
  int overflow_sets;
  int results_checked;

  descending_bubble_sort_with_tag_unit #(
    .CAPACITY(SORT_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .price_i       (price_i),
    .tag_i         (tag_i),
    .last_in_i     (last_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_price_o(sorted_price_o),
    .sorted_tag_o  (sorted_tag_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  // behavioral sorter: collect the set, sort on the last record
  task automatic record_accepted(input dbs_pkg::record_t rec, input logic last);
    dbs_pkg::record_t tmp;
    sorted_result_t   res;
    int               n;
    int               p;
    int               j;
    int               k;
    if (held_records.size() < SORT_DEPTH) begin
      held_records.push_back(rec);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      n = held_records.size();
      for (p = 1; p < n; p++) begin
        for (j = 0; j + 1 < n; j++) begin
          if (held_records[j].price < held_records[j+1].price) begin
            tmp               = held_records[j];
            held_records[j]   = held_records[j+1];
            held_records[j+1] = tmp;
          end
        end
      end
      for (k = 0; k < n; k++) begin
        res.price    = held_records[k].price;
        res.tag      = held_records[k].tag;
        res.last     = (k == n - 1);
        res.overflow = set_dropped;
        pending_results.push_back(res);
      end
      sets_sorted++;
      if (set_dropped) overflow_sets++;
      held_records.delete();
      set_dropped = 1'b0;
    end
  endtask

  // entered and left at a falling edge; valid stays high on return
  task automatic send_record(input logic [PRICE_W-1:0] price, input logic [TAG_W-1:0] tag,
                             input logic last);
    dbs_pkg::record_t rec;
    while (tx_idle_en && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    price_i    <= price;
    tag_i      <= tag;
    last_in_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rec.price = price;
    rec.tag   = tag;
    record_accepted(rec, last);
    records_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [PRICE_W-1:0] pick_price(input price_mode_e mode);
    case (mode)
      PRICE_NARROW: return PRICE_W'($urandom_range(7));
      PRICE_EXTREME: begin
        case ($urandom_range(3))
          0: return '0;
          1: return PRICE_MAX;
          2: return PRICE_MAX - PRICE_W'($urandom_range(3));
          default: return PRICE_W'($urandom_range(3));
        endcase
      end
      default: return PRICE_W'($urandom);
    endcase
  endfunction

  task automatic send_set(input int n, input price_mode_e mode);
    int i;
    for (i = 0; i < n; i++) begin
      send_record(pick_price(mode), TAG_W'($urandom_range(255)), i == n - 1);
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_cycles--;
    end else begin
      out_ready_i <= !(rx_idle_en && $urandom_range(99) < 13);
    end
  end

  always @(posedge clk_i) begin
    sorted_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result price %0h tag %0h", sorted_price_o,
                               sorted_tag_o));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (sorted_price_o !== want.price)
          report_error($sformatf("sorted_price got %0h expected %0h", sorted_price_o,
                                 want.price));
        if (sorted_tag_o !== want.tag)
          report_error($sformatf("sorted_tag got %0h expected %0h", sorted_tag_o, want.tag));
        if (last_out_o !== want.last)
          report_error($sformatf("last_out got %b expected %b", last_out_o, want.last));
        if (overflow_o !== want.overflow)
          report_error($sformatf("overflow got %b expected %b", overflow_o, want.overflow));
      end
    end
  end

  task automatic test_directed();
    int i;
    logic [PRICE_W-1:0] p;
    // single record at the top of both ranges
    send_record(PRICE_MAX, 8'hff, 1'b1);
    // equal prices keep load order
    send_record(31'd9, 8'd1, 1'b0);
    send_record(31'd5, 8'd2, 1'b0);
    send_record(31'd9, 8'd3, 1'b0);
    send_record(31'd5, 8'd4, 1'b1);
    // full store, the last transaction is the dropped one
    for (i = 0; i <= SORT_DEPTH; i++) begin
      if (i == 0) p = '0;
      else if (i == 15) p = PRICE_MAX;
      else p = PRICE_W'(i * 1000);
      send_record(p, TAG_W'(255 - i), i == SORT_DEPTH);
    end
    // overflow must clear for the next set
    send_record('0, 8'h00, 1'b1);
  endtask

  task automatic test_random();
    int n;
    int r;
    int stop_at;
    stop_at = records_sent + 300;
    while (records_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) n = $urandom_range(SORT_DEPTH + 5, SORT_DEPTH + 1);
      else if (r < 20) n = SORT_DEPTH;
      else n = $urandom_range(SORT_DEPTH, 1);
      send_set(n, price_mode_e'($urandom_range(2)));
    end
  endtask

  // receiver holds off while full sets keep coming
  task automatic test_output_stall();
    int i;
    rx_hold_cycles = 400;
    for (i = 0; i < 3; i++) send_set(SORT_DEPTH, PRICE_ANY);
  endtask

  task automatic test_no_idle();
    int i;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (i = 0; i < 6; i++) send_set($urandom_range(SORT_DEPTH + 2, 2), price_mode_e'(i % 3));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    price_i         = '0;
    tag_i           = '0;
    last_in_i       = 1'b0;
    out_ready_i     = 1'b0;
    set_dropped     = 1'b0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    rx_hold_cycles  = 0;
    error_count     = 0;
    records_sent    = 0;
    sets_sorted     = 0;
    overflow_sets   = 0;
    results_checked = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random();
    test_output_stall();
    test_no_idle();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("run covered %0d records in %0d sets, %0d of them with dropped records",
             records_sent, sets_sorted, overflow_sets);
    $display("%0d sorted results checked, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("PASS descending_bubble_sort_with_tag_unit");
    end else begin
      $display("FAIL descending_bubble_sort_with_tag_unit");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL descending_bubble_sort_with_tag_unit");
    $finish;
  end

endmodule

// ===== descending_bubble_sort_with_tag_unit.f =====
+incdir+design
design/dbs_pkg.sv
design/descending_bubble_sort_with_tag_unit.sv
tb/sv/tb_descending_bubble_sort_with_tag_unit.sv
